>>> sv/swr_pkg.sv
// ----------------------------------------------------------------------------
// swr_pkg: sliding-window scalar recoder shared definitions
// Sizes, limits and types for the signed-digit recoder.
// ----------------------------------------------------------------------------
package swr_pkg;

    localparam int NUM_BITS   = 256;
    localparam int LOOKAHEAD  = 6;
    localparam int DIGIT_MAX  = 15;
    localparam int IN_BITS    = 256;
    localparam int MAX_GROUPS = 64;
    localparam int WORD_W     = 64;
    localparam int DIGIT_W    = 5;
    localparam int GROUP_W    = 6;

    // positions that are reported; higher ones never change lower digits
    localparam int RPT_BITS   = (NUM_BITS < 4 * MAX_GROUPS) ? NUM_BITS : 4 * MAX_GROUPS;
    localparam int NUM_GROUPS = (RPT_BITS + 3) / 4;

    localparam int POS_W  = $clog2(NUM_BITS);
    localparam int LA_W   = $clog2(NUM_BITS + LOOKAHEAD);
    localparam int STEP_W = $clog2(LOOKAHEAD + 2);
    localparam int ACC_W  = $clog2(DIGIT_MAX + (1 << LOOKAHEAD) + 1) + 1;
    localparam int EXT_W  = (NUM_BITS > IN_BITS) ? NUM_BITS : IN_BITS;

    typedef logic signed [DIGIT_W-1:0] digit_t;
    typedef logic signed [ACC_W-1:0]   acc_t;

endpackage

>>> sv/sliding_window_scalar_recoder.sv
// ----------------------------------------------------------------------------
// sliding_window_scalar_recoder: signed odd-digit window recoder
// Recodes a scalar into signed digits in -15..15, one position and one
// lookahead step at a time, and streams the digits out in groups of four.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+----------------------------
//   in      | sink      | in_valid / in_ready  | scalar_w0..scalar_w3
//   out     | source    | out_valid / out_ready| digit0..3, group_index,
//           |           |                      | last_group
//
// Steps: load, then per position a scan; a clear bit closes there, a set
//   bit goes on to lookahead (one lookahead bit a cycle) and a close.
//   The single lookahead/carry unit serves every position in turn.
// A carry is one wide increment of the remaining bits.
// Reset clears everything; in_ready is high whenever the recoder is idle.
// A finished group waits in the output register; the next group to finish
//   holds the sequencer until the waiting one is taken.
// ----------------------------------------------------------------------------
module sliding_window_scalar_recoder
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [swr_pkg::WORD_W-1:0]        scalar_w0,
    input  logic [swr_pkg::WORD_W-1:0]        scalar_w1,
    input  logic [swr_pkg::WORD_W-1:0]        scalar_w2,
    input  logic [swr_pkg::WORD_W-1:0]        scalar_w3,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [swr_pkg::DIGIT_W-1:0] digit0,
    output logic signed [swr_pkg::DIGIT_W-1:0] digit1,
    output logic signed [swr_pkg::DIGIT_W-1:0] digit2,
    output logic signed [swr_pkg::DIGIT_W-1:0] digit3,
    output logic [swr_pkg::GROUP_W-1:0]       group_index,
    output logic                              last_group
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LOOK
    } state_t;

    localparam logic [swr_pkg::POS_W-1:0] LAST_POS = swr_pkg::POS_W'(swr_pkg::RPT_BITS - 1);

    state_t                            state_reg, state_next;
    logic [swr_pkg::NUM_BITS-1:0]      bits_reg, bits_next;
    logic [swr_pkg::POS_W-1:0]         pos_reg, pos_next;
    logic [swr_pkg::STEP_W-1:0]        step_reg, step_next;
    swr_pkg::acc_t                     acc_reg, acc_next;
    swr_pkg::digit_t                   grp_reg [0:2];
    swr_pkg::digit_t                   grp_next [0:2];
    logic                              out_valid_reg, out_valid_next;
    swr_pkg::digit_t                   d0_reg, d0_next;
    swr_pkg::digit_t                   d1_reg, d1_next;
    swr_pkg::digit_t                   d2_reg, d2_next;
    swr_pkg::digit_t                   d3_reg, d3_next;
    logic [swr_pkg::GROUP_W-1:0]       gidx_reg, gidx_next;
    logic                              last_reg, last_next;

    logic [4*swr_pkg::WORD_W-1:0]      in_vec;
    logic [swr_pkg::EXT_W-1:0]         in_ext;
    logic [swr_pkg::LA_W-1:0]          la;
    logic                              la_in;
    logic                              la_bit;
    swr_pkg::acc_t                     add_val;
    swr_pkg::acc_t                     acc_sum;
    swr_pkg::acc_t                     acc_dif;
    logic [1:0]                        slot;
    logic                              grp_end;
    logic                              out_free;
    logic                              commit;
    logic                              do_commit;
    swr_pkg::digit_t                   dig;

    assign in_vec   = {scalar_w3, scalar_w2, scalar_w1, scalar_w0};
    assign in_ext   = swr_pkg::EXT_W'(in_vec);
    assign la       = swr_pkg::LA_W'(pos_reg) + swr_pkg::LA_W'(step_reg);
    assign la_in    = (la < swr_pkg::LA_W'(swr_pkg::NUM_BITS))
                      && (step_reg <= swr_pkg::STEP_W'(swr_pkg::LOOKAHEAD));
    assign la_bit   = la_in && bits_reg[la[swr_pkg::POS_W-1:0]];
    assign add_val  = swr_pkg::acc_t'(swr_pkg::ACC_W'(1) << step_reg);
    assign acc_sum  = acc_reg + add_val;
    assign acc_dif  = acc_reg - add_val;
    assign slot     = pos_reg[1:0];
    assign grp_end  = (slot == 2'd3) || (pos_reg == LAST_POS);
    assign out_free = !out_valid_reg || out_ready;
    assign do_commit = commit && (!grp_end || out_free);

    always_comb
    begin
        state_next     = state_reg;
        bits_next      = bits_reg;
        pos_next       = pos_reg;
        step_next      = step_reg;
        acc_next       = acc_reg;
        grp_next       = grp_reg;
        out_valid_next = out_valid_reg && !out_ready;
        d0_next        = d0_reg;
        d1_next        = d1_reg;
        d2_next        = d2_reg;
        d3_next        = d3_reg;
        gidx_next      = gidx_reg;
        last_next      = last_reg;
        commit         = 1'b0;
        dig            = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    bits_next  = in_ext[swr_pkg::NUM_BITS-1:0];
                    pos_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (bits_reg[pos_reg])
                begin
                    acc_next   = swr_pkg::acc_t'(1);
                    step_next  = swr_pkg::STEP_W'(1);
                    state_next = ST_LOOK;
                end
                else
                begin
                    commit = 1'b1;
                end
            end
            ST_LOOK:
            begin
                dig = acc_reg[swr_pkg::DIGIT_W-1:0];
                if (!la_in)
                begin
                    commit = 1'b1;
                end
                else if (!la_bit)
                begin
                    step_next = step_reg + 1'b1;
                end
                else if (acc_sum <= swr_pkg::acc_t'(swr_pkg::DIGIT_MAX))
                begin
                    acc_next = acc_sum;
                    bits_next[la[swr_pkg::POS_W-1:0]] = 1'b0;
                    step_next = step_reg + 1'b1;
                end
                else if (acc_dif >= -swr_pkg::acc_t'(swr_pkg::DIGIT_MAX))
                begin
                    // carry ripples upward; overflow past the top is lost
                    acc_next  = acc_dif;
                    bits_next = bits_reg
                                + (swr_pkg::NUM_BITS'(1) << la[swr_pkg::POS_W-1:0]);
                    step_next = step_reg + 1'b1;
                end
                else
                begin
                    commit = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (do_commit)
        begin
            if (slot != 2'd3)
            begin
                grp_next[slot] = dig;
            end
            if (grp_end)
            begin
                out_valid_next = 1'b1;
                d0_next   = (slot == 2'd0) ? dig : grp_reg[0];
                d1_next   = (slot == 2'd1) ? dig : ((slot > 2'd1) ? grp_reg[1] : '0);
                d2_next   = (slot == 2'd2) ? dig : ((slot == 2'd3) ? grp_reg[2] : '0);
                d3_next   = (slot == 2'd3) ? dig : '0;
                gidx_next = swr_pkg::GROUP_W'(pos_reg >> 2);
                last_next = (pos_reg == LAST_POS);
            end
            if (pos_reg == LAST_POS)
            begin
                state_next = ST_IDLE;
            end
            else
            begin
                pos_next   = pos_reg + 1'b1;
                state_next = ST_SCAN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bits_reg      <= '0;
            pos_reg       <= '0;
            step_reg      <= '0;
            acc_reg       <= '0;
            grp_reg       <= '{default: '0};
            out_valid_reg <= 1'b0;
            d0_reg        <= '0;
            d1_reg        <= '0;
            d2_reg        <= '0;
            d3_reg        <= '0;
            gidx_reg      <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bits_reg      <= bits_next;
            pos_reg       <= pos_next;
            step_reg      <= step_next;
            acc_reg       <= acc_next;
            grp_reg       <= grp_next;
            out_valid_reg <= out_valid_next;
            d0_reg        <= d0_next;
            d1_reg        <= d1_next;
            d2_reg        <= d2_next;
            d3_reg        <= d3_next;
            gidx_reg      <= gidx_next;
            last_reg      <= last_next;
        end
    end

    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign digit0      = d0_reg;
    assign digit1      = d1_reg;
    assign digit2      = d2_reg;
    assign digit3      = d3_reg;
    assign group_index = gidx_reg;
    assign last_group  = last_reg;

    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_group |-> group_index == swr_pkg::GROUP_W'(swr_pkg::NUM_GROUPS - 1))
        else $error("last group carries wrong index");

    a_digit_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((digit0 == '0) || (digit0[0] && digit0 != -swr_pkg::digit_t'(16)))
                   && ((digit1 == '0) || (digit1[0] && digit1 != -swr_pkg::digit_t'(16)))
                   && ((digit2 == '0) || (digit2[0] && digit2 != -swr_pkg::digit_t'(16)))
                   && ((digit3 == '0) || (digit3[0] && digit3 != -swr_pkg::digit_t'(16))))
        else $error("digit not zero or odd in range");

    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == ST_SCAN && pos_reg == '0)
        else $error("item load did not start scan at position zero");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        do_commit && grp_end |-> out_free)
        else $error("group emitted over a waiting item");

    a_acc_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LOOK |-> acc_reg[0]
            && acc_reg <= swr_pkg::acc_t'(swr_pkg::DIGIT_MAX)
            && acc_reg >= -swr_pkg::acc_t'(swr_pkg::DIGIT_MAX))
        else $error("window accumulator left odd digit range");

endmodule

>>> tb/sv/recoder_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// recoder_checker: scoreboard for the sliding-window scalar recoder
// Watches both channels. Each accepted scalar is recoded here into signed
// digit groups. Each accepted output group is compared field by field with
// the oldest group still waiting. Mismatches and the number of groups still
// outstanding are passed up to the top.
// ----------------------------------------------------------------------------
module recoder_checker
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_ready,
    input  logic [swr_pkg::WORD_W-1:0]         scalar_w0,
    input  logic [swr_pkg::WORD_W-1:0]         scalar_w1,
    input  logic [swr_pkg::WORD_W-1:0]         scalar_w2,
    input  logic [swr_pkg::WORD_W-1:0]         scalar_w3,
    input  logic                               out_valid,
    input  logic                               out_ready,
    input  logic signed [swr_pkg::DIGIT_W-1:0] digit0,
    input  logic signed [swr_pkg::DIGIT_W-1:0] digit1,
    input  logic signed [swr_pkg::DIGIT_W-1:0] digit2,
    input  logic signed [swr_pkg::DIGIT_W-1:0] digit3,
    input  logic [swr_pkg::GROUP_W-1:0]        group_index,
    input  logic                               last_group,
    output int                                 fail_count,
    output int                                 pending
);

    typedef struct packed {
        swr_pkg::digit_t             d0;
        swr_pkg::digit_t             d1;
        swr_pkg::digit_t             d2;
        swr_pkg::digit_t             d3;
        logic [swr_pkg::GROUP_W-1:0] grp;
        logic                        last;
    } digit_group_t;

    digit_group_t digit_groups_due[$];

    task automatic report_mismatch(input string what);
        begin
            $display("%0t mismatch: %s", $realtime, what);
            fail_count++;
        end
    endtask

    function automatic void recode_scalar(input logic [swr_pkg::IN_BITS-1:0] s);
        int              dig[swr_pkg::NUM_BITS];
        int              add;
        int              pos;
        swr_pkg::digit_t quad[4];
        digit_group_t    g;
        begin
            for (int i = 0; i < swr_pkg::NUM_BITS; i++)
            begin
                if (i < swr_pkg::IN_BITS)
                    dig[i] = int'(s[i]);
                else
                    dig[i] = 0;
            end
            for (int i = 0; i < swr_pkg::NUM_BITS; i++)
            begin
                if (dig[i] == 0)
                    continue;
                for (int b = 1; b <= swr_pkg::LOOKAHEAD && (i + b) < swr_pkg::NUM_BITS; b++)
                begin
                    if (dig[i + b] == 0)
                        continue;
                    add = dig[i + b] * (1 << b);
                    if (dig[i] + add <= swr_pkg::DIGIT_MAX)
                    begin
                        dig[i] += add;
                        dig[i + b] = 0;
                    end
                    else if (dig[i] - add >= -swr_pkg::DIGIT_MAX)
                    begin
                        dig[i] -= add;
                        // +1 ripples up; a carry off the top is lost
                        for (int k = i + b; k < swr_pkg::NUM_BITS; k++)
                        begin
                            if (dig[k] == 0)
                            begin
                                dig[k] = 1;
                                break;
                            end
                            dig[k] = 0;
                        end
                    end
                    else
                    begin
                        break;
                    end
                end
            end
            for (int gi = 0; gi < swr_pkg::NUM_GROUPS; gi++)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    pos = 4 * gi + j;
                    quad[j] = (pos < swr_pkg::NUM_BITS) ? swr_pkg::digit_t'(dig[pos])
                                                        : swr_pkg::digit_t'(0);
                end
                g.d0   = quad[0];
                g.d1   = quad[1];
                g.d2   = quad[2];
                g.d3   = quad[3];
                g.grp  = gi[swr_pkg::GROUP_W-1:0];
                g.last = (gi == swr_pkg::NUM_GROUPS - 1);
                digit_groups_due.push_back(g);
            end
        end
    endfunction

    always @(posedge clk)
    begin
        digit_group_t got;
        digit_group_t want;
        int           got_f[6];
        int           want_f[6];
        string        names[6];
        if (rst_n)
        begin
            if (in_valid && in_ready)
                recode_scalar({scalar_w3, scalar_w2, scalar_w1, scalar_w0});
            if (out_valid && out_ready)
            begin
                got = {digit0, digit1, digit2, digit3, group_index, last_group};
                if (digit_groups_due.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected group %0d", group_index));
                end
                else
                begin
                    want = digit_groups_due.pop_front();
                    names  = '{"digit0", "digit1", "digit2", "digit3",
                               "group_index", "last_group"};
                    got_f  = '{int'(got.d0), int'(got.d1), int'(got.d2), int'(got.d3),
                               int'(got.grp), int'(got.last)};
                    want_f = '{int'(want.d0), int'(want.d1), int'(want.d2),
                               int'(want.d3), int'(want.grp), int'(want.last)};
                    for (int f = 0; f < 6; f++)
                    begin
                        if (got_f[f] != want_f[f])
                            report_mismatch($sformatf("group %0d %s got %0d want %0d",
                                                      want.grp, names[f],
                                                      got_f[f], want_f[f]));
                    end
                end
            end
            pending = digit_groups_due.size();
        end
    end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: sliding-window scalar recoder
// Drives directed and random 256-bit scalars into the recoder, with random
// gaps on the input and random back-pressure on the digit output, and
// gives the verdict from the checker's mismatch count and a stall watchdog.
// ----------------------------------------------------------------------------
module testbench;

    localparam int ITEM_COUNT   = 150;
    localparam int IDLE_PCT     = 35;
    localparam int QUIET_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 100;

    logic                        clk         = 1'b0;
    logic                        rst_n       = 1'b0;
    logic                        in_valid    = 1'b0;
    logic                        in_ready;
    logic [swr_pkg::WORD_W-1:0]  scalar_w0   = '0;
    logic [swr_pkg::WORD_W-1:0]  scalar_w1   = '0;
    logic [swr_pkg::WORD_W-1:0]  scalar_w2   = '0;
    logic [swr_pkg::WORD_W-1:0]  scalar_w3   = '0;
    logic                        out_valid;
    logic                        out_ready   = 1'b0;
    swr_pkg::digit_t             digit0;
    swr_pkg::digit_t             digit1;
    swr_pkg::digit_t             digit2;
    swr_pkg::digit_t             digit3;
    logic [swr_pkg::GROUP_W-1:0] group_index;
    logic                        last_group;
    int                          fail_count;
    int                          pending;
    int                          quiet_cycles = 0;
    bit                          steady       = 1'b0;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    sliding_window_scalar_recoder dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .scalar_w0   (scalar_w0),
        .scalar_w1   (scalar_w1),
        .scalar_w2   (scalar_w2),
        .scalar_w3   (scalar_w3),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .digit0      (digit0),
        .digit1      (digit1),
        .digit2      (digit2),
        .digit3      (digit3),
        .group_index (group_index),
        .last_group  (last_group)
    );

    recoder_checker scoreboard
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .scalar_w0   (scalar_w0),
        .scalar_w1   (scalar_w1),
        .scalar_w2   (scalar_w2),
        .scalar_w3   (scalar_w3),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .digit0      (digit0),
        .digit1      (digit1),
        .digit2      (digit2),
        .digit3      (digit3),
        .group_index (group_index),
        .last_group  (last_group),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    always @(negedge clk)
    begin
        out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [255:0] rand_bits();
        begin
            return {$urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom, $urandom};
        end
    endfunction

    function automatic logic [255:0] random_scalar();
        logic [255:0] a;
        logic [255:0] b;
        logic [255:0] c;
        logic [255:0] s;
        int           lo;
        int           len;
        begin
            a = rand_bits();
            b = rand_bits();
            c = rand_bits();
            s = '0;
            case ($urandom_range(0, 5))
                0: s = a;
                1: s = a & b & c;
                2: s = a | b | c;
                3:
                begin
                    // one to six runs of ones
                    repeat ($urandom_range(1, 6))
                    begin
                        lo  = $urandom_range(0, 255);
                        len = $urandom_range(1, 20);
                        for (int k = 0; k < len; k++)
                            s[(lo + k) % 256] = 1'b1;
                    end
                end
                4: s = a >> $urandom_range(0, 255);
                default: s = ~(a & b & c);
            endcase
            return s;
        end
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic push_scalar(input logic [255:0] s);
        begin
            while (!steady && $urandom_range(0, 99) < IDLE_PCT)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
            in_valid  <= 1'b1;
            scalar_w0 <= s[63:0];
            scalar_w1 <= s[127:64];
            scalar_w2 <= s[191:128];
            scalar_w3 <= s[255:192];
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            @(negedge clk);
        end
    endtask

    initial
    begin
        logic [255:0] directed[$];
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        directed = '{
            256'h0,
            ~256'h0,
            256'h1,
            256'h1 << 255,
            256'h3,
            256'h21,
            256'h11,
            256'h41,
            256'hF,
            256'h1F,
            {4{64'h5555_5555_5555_5555}},
            {4{64'hAAAA_AAAA_AAAA_AAAA}},
            256'h3F << 250,
            256'h3 << 254,
            {4{64'h8000_0000_0000_0001}},
            {4{64'h0F0F_0F0F_0F0F_0F0F}},
            {4{64'h3333_3333_3333_3333}},
            ~256'h1,
            {192'h0, 64'hFFFF_FFFF_FFFF_FFFF},
            {128'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0},
            {64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 128'h0},
            {64'hFFFF_FFFF_FFFF_FFFF, 192'h0},
            (256'h1 << 255) | 256'h1
        };
        foreach (directed[i])
            push_scalar(directed[i]);

        // hold off until the recoder has drained
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);

        for (int n = 0; n < ITEM_COUNT; n++)
        begin
            steady = (n >= 60 && n < 90);
            push_scalar(random_scalar());
        end
        steady = 1'b0;
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
